// ===== rtl/rae_pkg.sv =====
// Package for the RADIUS attribute extractor: scan phases, status codes,
// field widths and the value length check. Depends on nothing.
package rae_pkg;

    localparam int BYTE_W      = 8;
    localparam int VENDOR_W    = 32;
    localparam int VTYPE_W     = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_VENDOR_ID     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTRIBUTE_ID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_TYPE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DICT_PRESENT  = 2'd3;

    localparam logic [BYTE_W-1:0] VSA_TYPE      = 8'd26;
    localparam logic [BYTE_W-1:0] TLV_HDR_LEN   = 8'd2;
    localparam logic [BYTE_W-1:0] VENDOR_ID_LEN = 8'd4;
    localparam logic [BYTE_W-1:0] IPV4_LEN      = 8'd4;
    localparam logic [BYTE_W-1:0] IPV6_LEN      = 8'd16;

    typedef enum logic [2:0] {
        PH_TOP_TYPE = 3'd0,
        PH_TOP_LEN  = 3'd1,
        PH_VENDOR   = 3'd2,
        PH_SUB_TYPE = 3'd3,
        PH_SUB_LEN  = 3'd4,
        PH_SKIP     = 3'd5,
        PH_VALUE    = 3'd6,
        PH_SUB_SKIP = 3'd7
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND      = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_MALFORMED  = 2'd3
    } status_t;

    typedef enum logic [VTYPE_W-1:0] {
        VT_STRING  = 3'd0,
        VT_IPV4    = 3'd1,
        VT_IPV6    = 3'd2,
        VT_INTEGER = 3'd3,
        VT_OCTETS  = 3'd4
    } value_type_t;

    // A value of the given length is acceptable for the value type.
    function automatic logic length_ok(input logic [VTYPE_W-1:0] vtype,
                                       input logic [BYTE_W-1:0] len);
        logic ok;
        case (vtype)
            VT_STRING, VT_OCTETS: ok = 1'b1;
            VT_IPV4, VT_INTEGER:  ok = (len == IPV4_LEN);
            VT_IPV6:              ok = (len == IPV6_LEN);
            default:              ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== rtl/radius_attribute_extractor.sv =====
// Top level of the RADIUS attribute extractor: byte-wide attribute walker
// with a registered result stage. Depends on rae_pkg.
//
// The block takes one byte of a RADIUS attribute area per cycle and
// accepts a new byte in every cycle while the result register is free or
// being drained; each accepted byte updates the scan state in the same
// cycle, and any result it causes appears in the result register on the
// next cycle. Results are the value bytes of the first matching attribute,
// with m_tlast set on the result that ends the search for the packet and
// its status in m_tuser. Registers are meant to be written between packets.
module radius_attribute_extractor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rae_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] packet_byte
    input  logic                                s_tlast,   // end_of_packet
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*rae_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] value_byte, [15:8] value_length
    output logic [rae_pkg::STATUS_W:0]          m_tuser,   // [0] has_value, [2:1] status
    output logic                                m_tlast,   // done_res
    input  logic                                cfg_we,
    input  logic [rae_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rae_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rae_pkg::*;

    logic [VENDOR_W-1:0] vendor_id_reg;
    logic [BYTE_W-1:0]   attribute_id_reg;
    logic [VTYPE_W-1:0]  value_type_reg;
    logic                dict_present_reg;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   attr_rem_reg, attr_rem_next;
    logic [BYTE_W-1:0]   sub_rem_reg, sub_rem_next;
    logic [1:0]          vendor_idx_reg, vendor_idx_next;
    logic                vendor_match_reg, vendor_match_next;
    logic                is_match_reg, is_match_next;
    logic                finished_reg, finished_next;
    logic [BYTE_W-1:0]   found_len_reg, found_len_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_vbyte_reg;
    logic [BYTE_W-1:0]   out_vlen_reg;
    logic                out_has_reg;
    logic                out_done_reg;
    status_t             out_status_reg;

    logic                accept;
    logic                res_valid, res_done, res_has;
    status_t             res_status;
    logic [BYTE_W-1:0]   res_vbyte, res_vlen;
    logic [BYTE_W-1:0]   b;
    logic [BYTE_W-1:0]   n;
    logic [BYTE_W-1:0]   vendor_byte;
    logic                eop;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign eop      = s_tlast;
    assign n        = b - TLV_HDR_LEN;
    assign vendor_byte = vendor_id_reg[{~vendor_idx_reg, 3'b000} +: BYTE_W];

    always_comb begin
        phase_next        = phase_reg;
        attr_rem_next     = attr_rem_reg;
        sub_rem_next      = sub_rem_reg;
        vendor_idx_next   = vendor_idx_reg;
        vendor_match_next = vendor_match_reg;
        is_match_next     = is_match_reg;
        finished_next     = finished_reg;
        found_len_next    = found_len_reg;
        res_done   = 1'b0;
        res_has    = 1'b0;
        res_status = ST_FOUND;
        res_vbyte  = '0;
        res_vlen   = '0;

        if (finished_reg) begin
            if (eop) begin
                finished_next = 1'b0;
            end
        end else begin
            if (!dict_present_reg) begin
                res_done   = 1'b1;
                res_status = ST_NOT_FOUND;
            end else begin
                case (phase_reg)
                    PH_TOP_TYPE: begin
                        is_match_next     = (&vendor_id_reg) && (b == attribute_id_reg);
                        vendor_match_next = !vendor_id_reg[VENDOR_W-1] && (b == VSA_TYPE);
                        phase_next        = PH_TOP_LEN;
                    end
                    PH_TOP_LEN: begin
                        if (b < TLV_HDR_LEN) begin
                            res_done   = 1'b1;
                            res_status = ST_MALFORMED;
                        end else if (is_match_reg) begin
                            if (!length_ok(value_type_reg, n)) begin
                                res_done   = 1'b1;
                                res_status = ST_BAD_LENGTH;
                            end else if (n == '0) begin
                                res_done   = 1'b1;
                                res_status = ST_FOUND;
                            end else begin
                                found_len_next = n;
                                sub_rem_next   = n;
                                phase_next     = PH_VALUE;
                            end
                        end else if (n == '0) begin
                            phase_next = PH_TOP_TYPE;
                        end else begin
                            attr_rem_next = n;
                            if (vendor_match_reg && n >= VENDOR_ID_LEN) begin
                                vendor_idx_next = 2'd0;
                                phase_next      = PH_VENDOR;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_VENDOR: begin
                        if (b != vendor_byte) begin
                            vendor_match_next = 1'b0;
                        end
                        attr_rem_next = attr_rem_reg - 8'd1;
                        if (vendor_idx_reg == 2'd3) begin
                            vendor_idx_next = 2'd0;
                            if (attr_rem_next == '0) begin
                                phase_next = PH_TOP_TYPE;
                            end else if (vendor_match_next) begin
                                phase_next = PH_SUB_TYPE;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end else begin
                            vendor_idx_next = vendor_idx_reg + 2'd1;
                        end
                    end
                    PH_SUB_TYPE: begin
                        attr_rem_next = attr_rem_reg - 8'd1;
                        is_match_next = (b == attribute_id_reg);
                        if (attr_rem_next == '0) begin
                            if (is_match_next) begin
                                res_done   = 1'b1;
                                res_status = ST_MALFORMED;
                            end else begin
                                phase_next = PH_TOP_TYPE;
                            end
                        end else begin
                            phase_next = PH_SUB_LEN;
                        end
                    end
                    PH_SUB_LEN: begin
                        attr_rem_next = attr_rem_reg - 8'd1;
                        if (b < TLV_HDR_LEN || n > attr_rem_next) begin
                            res_done   = 1'b1;
                            res_status = ST_MALFORMED;
                        end else if (is_match_reg) begin
                            if (!length_ok(value_type_reg, n)) begin
                                res_done   = 1'b1;
                                res_status = ST_BAD_LENGTH;
                            end else if (n == '0) begin
                                res_done   = 1'b1;
                                res_status = ST_FOUND;
                            end else begin
                                found_len_next = n;
                                sub_rem_next   = n;
                                phase_next     = PH_VALUE;
                            end
                        end else if (n == '0) begin
                            phase_next = (attr_rem_next == '0) ? PH_TOP_TYPE : PH_SUB_TYPE;
                        end else begin
                            sub_rem_next = n;
                            phase_next   = PH_SUB_SKIP;
                        end
                    end
                    PH_SUB_SKIP: begin
                        attr_rem_next = attr_rem_reg - 8'd1;
                        sub_rem_next  = sub_rem_reg - 8'd1;
                        if (sub_rem_next == '0) begin
                            phase_next = (attr_rem_next == '0) ? PH_TOP_TYPE : PH_SUB_TYPE;
                        end
                    end
                    PH_SKIP: begin
                        attr_rem_next = attr_rem_reg - 8'd1;
                        if (attr_rem_next == '0) begin
                            phase_next = PH_TOP_TYPE;
                        end
                    end
                    PH_VALUE: begin
                        res_has      = 1'b1;
                        res_vbyte    = b;
                        sub_rem_next = sub_rem_reg - 8'd1;
                        if (sub_rem_next == '0) begin
                            res_done   = 1'b1;
                            res_status = ST_FOUND;
                            res_vlen   = found_len_reg;
                        end
                    end
                    default: begin
                        phase_next = PH_TOP_TYPE;
                    end
                endcase
                if (!res_done && eop) begin
                    res_done   = 1'b1;
                    res_has    = 1'b0;
                    res_vbyte  = '0;
                    res_status = (phase_next == PH_TOP_TYPE) ? ST_NOT_FOUND : ST_MALFORMED;
                end
            end
            if (res_done && !eop) begin
                finished_next = 1'b1;
            end
        end

        // The final byte of a packet returns the walker to its starting state.
        if (eop && (finished_reg || res_done)) begin
            phase_next        = PH_TOP_TYPE;
            attr_rem_next     = '0;
            sub_rem_next      = '0;
            vendor_idx_next   = 2'd0;
            vendor_match_next = 1'b1;
            is_match_next     = 1'b0;
            finished_next     = 1'b0;
            found_len_next    = '0;
        end
    end

    assign res_valid = !finished_reg && (res_done || res_has);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept && res_valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vendor_id_reg    <= '1;
            attribute_id_reg <= 8'd1;
            value_type_reg   <= VT_STRING;
            dict_present_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VENDOR_ID:    vendor_id_reg    <= cfg_data[VENDOR_W-1:0];
                CFG_ATTRIBUTE_ID: attribute_id_reg <= cfg_data[BYTE_W-1:0];
                CFG_VALUE_TYPE:   value_type_reg   <= cfg_data[VTYPE_W-1:0];
                CFG_DICT_PRESENT: dict_present_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_TOP_TYPE;
            attr_rem_reg     <= '0;
            sub_rem_reg      <= '0;
            vendor_idx_reg   <= 2'd0;
            vendor_match_reg <= 1'b1;
            is_match_reg     <= 1'b0;
            finished_reg     <= 1'b0;
            found_len_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                phase_reg        <= phase_next;
                attr_rem_reg     <= attr_rem_next;
                sub_rem_reg      <= sub_rem_next;
                vendor_idx_reg   <= vendor_idx_next;
                vendor_match_reg <= vendor_match_next;
                is_match_reg     <= is_match_next;
                finished_reg     <= finished_next;
                found_len_reg    <= found_len_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_vbyte_reg  <= res_vbyte;
            out_vlen_reg   <= res_vlen;
            out_has_reg    <= res_has;
            out_done_reg   <= res_done;
            out_status_reg <= res_done ? res_status : ST_FOUND;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_vlen_reg, out_vbyte_reg};
    assign m_tuser  = {out_status_reg, out_has_reg};
    assign m_tlast  = out_done_reg;

endmodule
